/* sv/string_hash_bucket_index_defines.svh */
// Assertion macros for the string hash bucket index modules; shb_mod includes them.
`ifndef STRING_HASH_BUCKET_INDEX_DEFINES_SVH
`define STRING_HASH_BUCKET_INDEX_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SHB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/shb_pkg.sv */
// Shared types, constants and the hash step function for the string hash bucket index.
package shb_pkg;

  localparam int HASH_W = 32;
  localparam int CHAR_W = 8;
  localparam int SIZE_W = 16;
  localparam int CNT_W  = $clog2(HASH_W);
  localparam int ROT    = 5;

  localparam logic [HASH_W-1:0] HASH_SEED = 32'hBAE86554;

  // Request from the hash unit to the serial modulo unit
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] hash;
  } div_req_t;

  // Modulo unit states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } mod_state_t;

  // XOR with the sign-extended character, then rotate left
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [CHAR_W-1:0] c);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-CHAR_W){c[CHAR_W-1]}}, c};
    return {x[HASH_W-1-ROT:0], x[HASH_W-1:HASH_W-ROT]};
  endfunction

endpackage

/* sv/string_hash_bucket_index.sv */
// The running hash takes one word per clock while the block is idle. The word that ends a key
// starts a bit-serial modulo by table_size, one quotient bit per cycle over the 32 hash bits,
// and input is held off until the modulo ends. A finished result waits in the output register,
// and the next key can stream in meanwhile; if that result is still not taken when the next
// modulo ends, input stays held until it is. table_size is to be written through cfg_wen/
// cfg_wdata only while the block is idle; the block itself does not enforce this. Zero gives
// bucket index 0. Output tdata: bucket_index in [15:0], full_hash in [47:16].
module string_hash_bucket_index (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,     // table_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
  input  logic        s_axis_tuser,  // [0] char_absent
  input  logic        s_axis_tlast,  // end_of_key
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [15:0] bucket_index, [47:16] full_hash
);

  logic [shb_pkg::SIZE_W-1:0] table_size;
  logic                       in_fire;
  logic                       mod_idle;
  shb_pkg::div_req_t          req;

  // Table size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= shb_pkg::SIZE_W'(1);
    end else if (cfg_wen) begin
      table_size <= cfg_wdata;
    end
  end

  assign s_axis_tready = mod_idle;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  shb_hash u_hash (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_fire),
    .char_byte   (s_axis_tdata),
    .char_absent (s_axis_tuser),
    .end_of_key  (s_axis_tlast),
    .req         (req)
  );

  shb_mod u_mod (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .divisor    (table_size),
    .idle       (mod_idle),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_bucket (m_axis_tdata[15:0]),
    .out_hash   (m_axis_tdata[47:16])
  );

endmodule

/* sv/shb_hash.sv */
// Running hash register: folds in the character of each accepted word unless it is absent, seed reload at end of key.
module shb_hash (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [shb_pkg::CHAR_W-1:0]           char_byte,
  input  logic                                 char_absent,
  input  logic                                 end_of_key,
  output shb_pkg::div_req_t                    req
);

  logic [shb_pkg::HASH_W-1:0] running_hash;
  logic [shb_pkg::HASH_W-1:0] hash_val;

  // Hash including the current word
  assign hash_val = char_absent ? running_hash
                                : shb_pkg::hash_step(running_hash, char_byte);

  // Finished hash goes to the modulo unit on the end word
  assign req.start = accept & end_of_key;
  assign req.hash  = hash_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= shb_pkg::HASH_SEED;
    end else if (accept) begin
      running_hash <= end_of_key ? shb_pkg::HASH_SEED : hash_val;
    end
  end

endmodule

/* sv/shb_mod.sv */
// Bit-serial restoring modulo unit with output register.
`include "string_hash_bucket_index_defines.svh"

module shb_mod (
  input  logic                                 clk,
  input  logic                                 rst,
  input  shb_pkg::div_req_t                    req,
  input  logic [shb_pkg::SIZE_W-1:0]           divisor,
  output logic                                 idle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [shb_pkg::SIZE_W-1:0]           out_bucket,
  output logic [shb_pkg::HASH_W-1:0]           out_hash
);

  shb_pkg::mod_state_t          state;
  logic [shb_pkg::CNT_W-1:0]    cnt;
  logic [shb_pkg::HASH_W-1:0]   dvd;
  logic [shb_pkg::HASH_W-1:0]   hash;
  logic [shb_pkg::SIZE_W-1:0]   dvs;
  logic [shb_pkg::SIZE_W-1:0]   rem;
  logic [shb_pkg::SIZE_W:0]     rem_sh;
  logic [shb_pkg::SIZE_W:0]     rem_step;
  logic [shb_pkg::SIZE_W-1:0]   bucket;
  logic                         out_free;
  logic                         in_run;
  logic                         in_hold;
  logic                         out_load;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem, dvd[shb_pkg::HASH_W-1]};
  assign rem_step = (rem_sh >= {1'b0, dvs}) ? (rem_sh - {1'b0, dvs}) : rem_sh;
  // Zero table size gives bucket zero
  assign bucket   = (dvs == '0) ? '0 : rem_step[shb_pkg::SIZE_W-1:0];

  assign idle     = (state == shb_pkg::S_IDLE);
  assign in_run   = (state == shb_pkg::S_RUN);
  assign in_hold  = (state == shb_pkg::S_HOLD);
  assign out_free = ~out_valid | out_ready;
  // Result enters the output register once the last step is done and the slot is free
  assign out_load = ((in_run && (cnt == '0)) || in_hold) && out_free;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shb_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        shb_pkg::S_IDLE: begin
          if (req.start) begin
            state <= shb_pkg::S_RUN;
          end
        end
        shb_pkg::S_RUN: begin
          if (cnt == '0) begin
            if (out_free) begin
              state <= shb_pkg::S_IDLE;
            end else begin
              state <= shb_pkg::S_HOLD;
            end
          end
        end
        shb_pkg::S_HOLD: begin
          if (out_free) begin
            state <= shb_pkg::S_IDLE;
          end
        end
        default: begin
          state <= shb_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      shb_pkg::S_IDLE: begin
        if (req.start) begin
          dvd  <= req.hash;
          hash <= req.hash;
          dvs  <= divisor;
          rem  <= '0;
          cnt  <= shb_pkg::CNT_W'(shb_pkg::HASH_W - 1);
        end
      end
      shb_pkg::S_RUN: begin
        dvd <= {dvd[shb_pkg::HASH_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          rem <= bucket;
          if (out_free) begin
            out_bucket <= bucket;
            out_hash   <= hash;
          end
        end else begin
          rem <= rem_step[shb_pkg::SIZE_W-1:0];
        end
      end
      shb_pkg::S_HOLD: begin
        if (out_free) begin
          out_bucket <= rem;
          out_hash   <= hash;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  `SHB_ASSERT_IMP(a_start_idle, req.start, state == shb_pkg::S_IDLE, "start while modulo busy")
  `SHB_ASSERT_IMP(a_rem_below, in_run && (dvs != '0), rem < dvs, "remainder out of range")
  `SHB_ASSERT_NXT(a_run_ends, in_run && (cnt == '0), !in_run, "modulo overran")
  `SHB_ASSERT_IMP(a_out_src, $rose(out_valid), $past(in_run || in_hold), "result without modulo")

endmodule

/* bench/tb_string_hash_bucket_index.sv */
`timescale 1ns / 1ps
// Testbench for string_hash_bucket_index: key words in, hash and bucket index checked out.
module tb_string_hash_bucket_index;

  // One key character word on the input stream
  typedef struct {
    logic [shb_pkg::CHAR_W-1:0] ch;
    logic                       absent;
    logic                       last;
  } key_word_t;

  // One hash result on the output stream
  typedef struct {
    logic [shb_pkg::SIZE_W-1:0] bucket;
    logic [shb_pkg::HASH_W-1:0] hash;
  } hash_result_t;

  localparam int MOD_SETTLE = 40;   // covers the modulo plus output hand-off
  localparam int PHASE_WORDS = 60;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] char_byte
  logic s_axis_tuser = 1'b0;       // [0] char_absent
  logic s_axis_tlast = 1'b0;       // end_of_key
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // [15:0] bucket_index, [47:16] full_hash

  key_word_t    key_words[$];
  hash_result_t expected_results[$];

  // Predictor state and its copy of the table size
  logic [shb_pkg::HASH_W-1:0] running_hash = shb_pkg::HASH_SEED;
  logic [shb_pkg::SIZE_W-1:0] bucket_count = 16'd1;

  logic took_word = 1'b0;
  int words_sent = 0;
  int hashes_checked = 0;
  int mismatches = 0;
  int sizes_used = 1;

  string_hash_bucket_index dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // XOR in the sign-extended character, then rotate left by five
  function automatic logic [shb_pkg::HASH_W-1:0] fold_char(
      input logic [shb_pkg::HASH_W-1:0] h,
      input logic [shb_pkg::CHAR_W-1:0] c);
    logic [shb_pkg::HASH_W-1:0] x;
    x = h ^ {{(shb_pkg::HASH_W-shb_pkg::CHAR_W){c[shb_pkg::CHAR_W-1]}}, c};
    return (x << 5) | (x >> (shb_pkg::HASH_W - 5));
  endfunction

  // Edge bytes show up often, the rest is random
  function automatic logic [shb_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return shb_pkg::CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_word(input logic [7:0] ch, input logic absent, input logic last);
    key_word_t w;
    w.ch = ch;
    w.absent = absent;
    w.last = last;
    key_words.push_back(w);
  endtask

  // Random key: empty keys, absent words mid-key, present or absent end word
  task automatic add_random_key(inout int counted);
    int len;
    if ($urandom_range(0, 9) == 0) begin
      add_word(shb_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      counted++;
    end else begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0)
          add_word(shb_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b0);
        add_word(pick_char(), 1'b0, 1'b0);
        counted++;
      end
      if ($urandom_range(0, 2) == 0)
        add_word(shb_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      else
        add_word(pick_char(), 1'b0, 1'b1);
      counted++;
    end
  endtask

  // Sender holds off until the block has drained and gone quiet
  task automatic wait_idle();
    while (key_words.size() != 0 || expected_results.size() != 0)
      @(negedge clk);
    repeat (MOD_SETTLE) @(negedge clk);
  endtask

  task automatic set_table_size(input logic [15:0] v);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    bucket_count = v;
    sizes_used++;
  endtask

  // Input side: prediction on every accepted word
  always @(posedge clk) begin : input_track
    key_word_t w;
    hash_result_t r;
    took_word <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      w = key_words.pop_front();
      words_sent++;
      if (!w.absent)
        running_hash = fold_char(running_hash, w.ch);
      if (w.last) begin
        r.hash = running_hash;
        r.bucket = (bucket_count == 0) ? '0 :
                   shb_pkg::SIZE_W'(running_hash % bucket_count);
        expected_results.push_back(r);
        running_hash = shb_pkg::HASH_SEED;
      end
    end
  end

  // Sender: bursts of words with random gaps, valid held until taken
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !took_word) begin
      // word still waiting for tready
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      s_axis_tvalid <= 1'b0;
    end else if (key_words.size() != 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= key_words[0].ch;
      s_axis_tuser <= key_words[0].absent;
      s_axis_tlast <= key_words[0].last;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: stall pattern switches between four modes
  int rx_left = 0;
  logic [1:0] rx_mode = 2'd0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= (rx_left % 16 < 4);
    endcase
  end

  // Output side: compare each word with the oldest expected result
  always @(posedge clk) begin : result_check
    hash_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: bucket %0d hash %h", m_axis_tdata[15:0],
                   m_axis_tdata[47:16]);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        hashes_checked++;
        if (m_axis_tdata[15:0] !== want.bucket || m_axis_tdata[47:16] !== want.hash) begin
          if (mismatches < 10)
            $display("mismatch on result %0d: bucket exp %0d got %0d, hash exp %h got %h",
                     hashes_checked, want.bucket, m_axis_tdata[15:0], want.hash,
                     m_axis_tdata[47:16]);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and phase control
  initial begin : stimulus
    logic [15:0] sizes[10];
    int counted;
    sizes = '{16'd1, 16'd2, 16'd3, 16'd7, 16'd256, 16'd65521, 16'd65535, 16'd0,
              16'd0, 16'd0};
    sizes[8] = 16'($urandom_range(1, 65535));
    sizes[9] = 16'($urandom_range(1, 65535));
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset table size of one: every bucket is zero
    add_word(8'hA5, 1'b1, 1'b1);
    add_word(8'h80, 1'b0, 1'b1);
    wait_idle();

    // Largest table: edge bytes, zero bytes inside a key, absent words
    set_table_size(16'd65535);
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'hFF, 1'b0, 1'b1);
    add_word(8'h7F, 1'b0, 1'b1);
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'h41, 1'b0, 1'b1);
    add_word(8'h41, 1'b0, 1'b0);
    add_word(8'hFF, 1'b1, 1'b0);
    add_word(8'h42, 1'b0, 1'b0);
    add_word(8'h00, 1'b1, 1'b1);
    add_word(8'h5A, 1'b1, 1'b1);
    add_word(8'h80, 1'b0, 1'b0);
    add_word(8'h7F, 1'b0, 1'b0);
    add_word(8'hFF, 1'b0, 1'b0);
    add_word(8'h01, 1'b0, 1'b1);
    wait_idle();

    // Zero table size gives bucket zero
    set_table_size(16'd0);
    add_word(8'h00, 1'b1, 1'b1);
    add_word(8'hFF, 1'b0, 1'b1);
    add_word(8'h33, 1'b0, 1'b0);
    add_word(8'hC3, 1'b1, 1'b1);
    wait_idle();

    // Random keys, one phase per table size; each phase drains before the next write
    foreach (sizes[p]) begin
      set_table_size(sizes[p]);
      counted = 0;
      while (counted < PHASE_WORDS)
        add_random_key(counted);
      wait_idle();
    end

    $display("Sent %0d key words and checked %0d hashes over %0d table size settings,",
             words_sent, hashes_checked, sizes_used);
    $display("including sizes 0, 1 and 65535, empty keys and absent words mid-key.");
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
